// ===== hdl/rsc_pkg.sv =====
package rsc_pkg;

    localparam int ROTORS     = 3;
    localparam int ALPHA      = 26;
    localparam int WIRE_DEPTH = ROTORS * ALPHA;
    localparam int AW         = $clog2(WIRE_DEPTH);
    localparam int RW         = (ROTORS > 1) ? $clog2(ROTORS) : 1;

    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [7:0] UPPER_A   = 8'h41;
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] UPPER_END = UPPER_A + 8'(ALPHA);
    localparam logic [7:0] LOWER_END = LOWER_A + 8'(ALPHA);

    typedef logic [4:0]    sym_t;
    typedef logic [RW-1:0] rotor_idx_t;
    typedef logic [AW-1:0] waddr_t;
    typedef logic [1:0]    upc_t;

    typedef enum logic [1:0] {
        ACT_CIPHER = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_POS    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        COND_ALWAYS      = 2'd0,
        COND_CIPHER_TAKE = 2'd1,
        COND_ROTOR_DONE  = 2'd2,
        COND_OUT_FREE    = 2'd3
    } cond_t;

    // microprogram steps
    localparam upc_t STEP_FETCH = 2'd0;
    localparam upc_t STEP_READ  = 2'd1;
    localparam upc_t STEP_EMIT  = 2'd2;

    typedef struct packed {
        logic  in_ready;
        logic  rd;
        logic  emit;
        cond_t cond;
        upc_t  tgt;
        upc_t  alt;
    } ctrl_t;

    function automatic ctrl_t ucode(input upc_t step);
        ctrl_t w;
        w = '{in_ready: 1'b0, rd: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
              tgt: STEP_FETCH, alt: STEP_FETCH};
        unique case (step)
            STEP_FETCH: begin
                w.in_ready = 1'b1;
                w.cond     = COND_CIPHER_TAKE;
                w.tgt      = STEP_READ;
                w.alt      = STEP_FETCH;
            end
            STEP_READ: begin
                w.rd   = 1'b1;
                w.cond = COND_ROTOR_DONE;
                w.tgt  = STEP_EMIT;
                w.alt  = STEP_READ;
            end
            STEP_EMIT: begin
                w.emit = 1'b1;
                w.cond = COND_OUT_FREE;
                w.tgt  = STEP_FETCH;
                w.alt  = STEP_EMIT;
            end
            default: begin
                w.cond = COND_ALWAYS;
                w.tgt  = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

    function automatic sym_t wrap_sym(input logic [4:0] v);
        return (v >= 5'(ALPHA)) ? sym_t'(v - 5'(ALPHA)) : v;
    endfunction

endpackage

// ===== hdl/rotor_substitution_cipher.sv =====
// Rotor substitution cipher over a byte stream.
// Input channel (s_valid/s_ready): each transaction carries an action.
//   Load wiring entry and set start position complete in the accept cycle
//   and give no result. Cipher gives exactly one result on the m_ channel.
// Result channel (m_valid/m_ready): m_cipher_byte is the ciphered letter in
//   the input's case, or the input byte unchanged when it is not a letter.
// Sequence: after accept, a cipher letter makes one wiring read per rotor
//   through the single read port of the wiring memory, chained through its
//   registered read data, and then the emit step loads the result register.
//   A non-letter passes through a single read step and then the emit step.
//   The next transaction is taken in the cycle after the result is loaded, so
//   a new cipher byte is not taken until the last one is emitted; load
//   transactions are taken back to back.
// Control is a three-step microprogram (fetch, read, emit) held in a
// constant table, with a step counter and conditional jumps.
// Reset clears the rotor positions, the step counter and m_valid. Wiring
// entries hold no reset value and must be loaded before use.
// A stalled receiver holds the result; one more cipher transaction is accepted and
// worked on, then the sequencer waits in the emit step until the result
// register frees up.
module rotor_substitution_cipher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_data_byte,
    input  logic [1:0] s_rotor_select,
    input  logic [4:0] s_entry_select,
    input  logic [4:0] s_entry_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cipher_byte
);

    rsc_pkg::upc_t       upc_reg, upc_next;
    rsc_pkg::ctrl_t      ctrl;
    rsc_pkg::rotor_idx_t r_reg, r_next;
    rsc_pkg::sym_t       pos_reg [rsc_pkg::ROTORS];
    rsc_pkg::sym_t       pos_next [rsc_pkg::ROTORS];
    rsc_pkg::sym_t       pos_step [rsc_pkg::ROTORS];
    rsc_pkg::sym_t       wiring_mem [rsc_pkg::WIRE_DEPTH];
    rsc_pkg::sym_t       rd_data_reg;
    rsc_pkg::waddr_t     rd_addr;
    rsc_pkg::waddr_t     wr_addr;
    logic                wr_en;

    logic [7:0]          byte_reg;
    rsc_pkg::sym_t       x_reg;
    logic                letter_reg;
    logic                lower_reg;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_byte_reg;

    logic                take;
    logic                in_upper, in_lower;
    logic                last_rotor;
    logic                out_free;
    logic                cond_hit;
    logic                do_emit;
    rsc_pkg::sym_t       x_cur;
    logic [5:0]          idx_sum;
    rsc_pkg::sym_t       idx;
    logic                carry;

    assign ctrl     = rsc_pkg::ucode(upc_reg);
    assign s_ready  = ctrl.in_ready;
    assign take     = s_valid && ctrl.in_ready;
    assign m_valid  = m_valid_reg;
    assign m_cipher_byte = m_byte_reg;

    assign in_upper = (s_data_byte >= rsc_pkg::UPPER_A) && (s_data_byte < rsc_pkg::UPPER_END);
    assign in_lower = (s_data_byte >= rsc_pkg::LOWER_A) && (s_data_byte < rsc_pkg::LOWER_END);

    assign last_rotor = (r_reg == rsc_pkg::rotor_idx_t'(rsc_pkg::ROTORS - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign do_emit    = ctrl.emit && out_free;

    // sequencer: branch on the condition the control word selects
    always_comb begin
        unique case (ctrl.cond)
            rsc_pkg::COND_ALWAYS:      cond_hit = 1'b1;
            rsc_pkg::COND_CIPHER_TAKE:
                cond_hit = take && (rsc_pkg::action_t'(s_action) == rsc_pkg::ACT_CIPHER);
            rsc_pkg::COND_ROTOR_DONE:  cond_hit = last_rotor || !letter_reg;
            rsc_pkg::COND_OUT_FREE:    cond_hit = out_free;
            default:                   cond_hit = 1'b1;
        endcase
        upc_next = cond_hit ? ctrl.tgt : ctrl.alt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= rsc_pkg::STEP_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // rotor counter: restart on fetch, advance per read
    always_comb begin
        if (ctrl.rd) begin
            r_next = last_rotor ? '0 : rsc_pkg::rotor_idx_t'(r_reg + 1'b1);
        end else if (ctrl.in_ready) begin
            r_next = '0;
        end else begin
            r_next = r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg <= '0;
        end else begin
            r_reg <= r_next;
        end
    end

    // latch a cipher byte and its folded offset
    always_ff @(posedge aclk) begin
        if (take && rsc_pkg::action_t'(s_action) == rsc_pkg::ACT_CIPHER) begin
            byte_reg   <= s_data_byte;
            x_reg      <= rsc_pkg::sym_t'((s_data_byte & rsc_pkg::CASE_MASK) - rsc_pkg::UPPER_A);
            letter_reg <= in_upper || in_lower;
            lower_reg  <= in_lower;
        end
    end

    // read address: rotor base plus (position + offset) mod 26
    always_comb begin
        x_cur   = (r_reg == '0) ? x_reg : rd_data_reg;
        idx_sum = {1'b0, pos_reg[r_reg]} + {1'b0, x_cur};
        idx     = (idx_sum >= 6'(rsc_pkg::ALPHA)) ? rsc_pkg::sym_t'(idx_sum - 6'(rsc_pkg::ALPHA))
                                                   : rsc_pkg::sym_t'(idx_sum);
        rd_addr = rsc_pkg::waddr_t'(rsc_pkg::waddr_t'(r_reg) * rsc_pkg::waddr_t'(rsc_pkg::ALPHA))
                  + rsc_pkg::waddr_t'(idx);
    end

    assign wr_en = take && (rsc_pkg::action_t'(s_action) == rsc_pkg::ACT_LOAD)
                   && (int'(s_rotor_select) < rsc_pkg::ROTORS)
                   && (int'(s_entry_select) < rsc_pkg::ALPHA);
    assign wr_addr = rsc_pkg::waddr_t'(rsc_pkg::waddr_t'(s_rotor_select)
                                       * rsc_pkg::waddr_t'(rsc_pkg::ALPHA))
                     + rsc_pkg::waddr_t'(s_entry_select);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wiring_mem[wr_addr] <= rsc_pkg::wrap_sym(s_entry_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd) begin
            rd_data_reg <= wiring_mem[rd_addr];
        end
    end

    // odometer step, rotor 0 fastest
    always_comb begin
        carry = 1'b1;
        for (int r = 0; r < rsc_pkg::ROTORS; r++) begin
            if (carry) begin
                if (pos_reg[r] == rsc_pkg::sym_t'(rsc_pkg::ALPHA - 1)) begin
                    pos_step[r] = '0;
                end else begin
                    pos_step[r] = rsc_pkg::sym_t'(pos_reg[r] + 1'b1);
                    carry       = 1'b0;
                end
            end else begin
                pos_step[r] = pos_reg[r];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < rsc_pkg::ROTORS; r++) begin
            if (do_emit && letter_reg) begin
                pos_next[r] = pos_step[r];
            end else if (take && rsc_pkg::action_t'(s_action) == rsc_pkg::ACT_POS
                         && int'(s_rotor_select) == r) begin
                pos_next[r] = rsc_pkg::wrap_sym(s_entry_value);
            end else begin
                pos_next[r] = pos_reg[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < rsc_pkg::ROTORS; r++) begin
                pos_reg[r] <= '0;
            end
        end else begin
            for (int r = 0; r < rsc_pkg::ROTORS; r++) begin
                pos_reg[r] <= pos_next[r];
            end
        end
    end

    // result register
    always_comb begin
        if (do_emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            if (letter_reg) begin
                m_byte_reg <= (lower_reg ? rsc_pkg::LOWER_A : rsc_pkg::UPPER_A)
                              + {3'b000, rd_data_reg};
            end else begin
                m_byte_reg <= byte_reg;
            end
        end
    end

endmodule

// ===== bench/rotor_substitution_cipher_tb.sv =====
module rotor_substitution_cipher_tb;

    logic       aclk;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [1:0] s_action       = rsc_pkg::ACT_NONE;
    logic [7:0] s_data_byte    = '0;
    logic [1:0] s_rotor_select = '0;
    logic [4:0] s_entry_select = '0;
    logic [4:0] s_entry_value  = '0;
    logic       m_valid;
    logic       m_ready        = 1'b1;
    logic [7:0] m_cipher_byte;

    // Shadow copy of the rotor machine
    rsc_pkg::sym_t wiring [rsc_pkg::ROTORS][rsc_pkg::ALPHA];
    rsc_pkg::sym_t rotor_pos [rsc_pkg::ROTORS] = '{default: '0};
    logic [7:0]    pending_bytes [$];

    bit sender_idles    = 1'b1;
    bit receiver_stalls = 1'b1;
    int stall_left      = 0;
    int mismatches      = 0;

    rotor_substitution_cipher dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_data_byte    (s_data_byte),
        .s_rotor_select (s_rotor_select),
        .s_entry_select (s_entry_select),
        .s_entry_value  (s_entry_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cipher_byte  (m_cipher_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("rotor_substitution_cipher verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s: got %02h, expected %02h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] encipher_byte(input logic [7:0] b);
        logic       is_upper;
        logic       is_lower;
        logic       carry;
        logic [4:0] x;
        is_upper = (b >= rsc_pkg::UPPER_A) && (b < rsc_pkg::UPPER_END);
        is_lower = (b >= rsc_pkg::LOWER_A) && (b < rsc_pkg::LOWER_END);
        if (!is_upper && !is_lower)
            return b;
        x = 5'((b & rsc_pkg::CASE_MASK) - rsc_pkg::UPPER_A);
        for (int r = 0; r < rsc_pkg::ROTORS; r++)
            x = wiring[r][(int'(rotor_pos[r]) + int'(x)) % rsc_pkg::ALPHA];
        // odometer step, rotor 0 fastest
        carry = 1'b1;
        for (int r = 0; r < rsc_pkg::ROTORS; r++) begin
            if (carry) begin
                if (rotor_pos[r] == rsc_pkg::sym_t'(rsc_pkg::ALPHA - 1)) begin
                    rotor_pos[r] = '0;
                end else begin
                    rotor_pos[r] = rotor_pos[r] + 5'd1;
                    carry = 1'b0;
                end
            end
        end
        return (is_lower ? rsc_pkg::LOWER_A : rsc_pkg::UPPER_A) + 8'(x);
    endfunction

    function automatic void apply_transaction(input rsc_pkg::action_t act,
                                              input logic [7:0] b,
                                              input logic [1:0] rs, input logic [4:0] es,
                                              input logic [4:0] ev);
        case (act)
            rsc_pkg::ACT_CIPHER: pending_bytes.push_back(encipher_byte(b));
            rsc_pkg::ACT_LOAD: begin
                if (int'(rs) < rsc_pkg::ROTORS && int'(es) < rsc_pkg::ALPHA)
                    wiring[rs][es] = rsc_pkg::sym_t'(int'(ev) % rsc_pkg::ALPHA);
            end
            rsc_pkg::ACT_POS: begin
                if (int'(rs) < rsc_pkg::ROTORS)
                    rotor_pos[rs] = rsc_pkg::sym_t'(int'(ev) % rsc_pkg::ALPHA);
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input rsc_pkg::action_t act, input logic [7:0] b,
                             input logic [1:0] rs,
                             input logic [4:0] es, input logic [4:0] ev);
        int n;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            @(negedge aclk) s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_action       <= act;
        s_data_byte    <= b;
        s_rotor_select <= rs;
        s_entry_select <= es;
        s_entry_value  <= ev;
        do @(posedge aclk); while (!s_ready);
        apply_transaction(act, b, rs, es, ev);
    endtask

    // unused fields get random filler
    task automatic send_cipher(input logic [7:0] b);
        send_item(rsc_pkg::ACT_CIPHER, b, 2'($urandom_range(0, 3)),
                  5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    endtask

    task automatic send_position(input logic [1:0] rs, input logic [4:0] ev);
        send_item(rsc_pkg::ACT_POS, 8'($urandom_range(0, 255)), rs,
                  5'($urandom_range(0, 31)), ev);
    endtask

    task automatic wait_for_results();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_result
        logic [7:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("result with nothing pending", m_cipher_byte, 8'h00);
            end else begin
                want = pending_bytes.pop_front();
                if (m_cipher_byte !== want)
                    report_mismatch("cipher_byte", m_cipher_byte, want);
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Non-letters do not use the wiring data, so they are safe before any load
    task automatic test_passthrough();
        logic [7:0] edges [8] = '{8'h00, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF, 8'h20, 8'h80};
        foreach (edges[i])
            send_cipher(edges[i]);
    endtask

    task automatic test_wiring_load();
        for (int r = 0; r < rsc_pkg::ROTORS; r++)
            for (int e = 0; e < rsc_pkg::ALPHA; e++)
                send_item(rsc_pkg::ACT_LOAD, 8'($urandom_range(0, 255)), 2'(r), 5'(e),
                          5'($urandom_range(0, 31)));
        // entries past the table and the missing rotor are dropped
        for (int e = rsc_pkg::ALPHA; e < 32; e++)
            send_item(rsc_pkg::ACT_LOAD, 8'h00, 2'($urandom_range(0, 2)), 5'(e), 5'd7);
        send_item(rsc_pkg::ACT_LOAD, 8'h00, 2'd3, 5'd4, 5'd9);
        send_item(rsc_pkg::ACT_LOAD, 8'h00, 2'd0, 5'd0, 5'd31);
        send_item(rsc_pkg::ACT_LOAD, 8'h00, 2'd2, 5'd25, 5'd26);
    endtask

    task automatic test_letter_extremes();
        logic [7:0] letters [8] = '{"A", "Z", "a", "z", "M", "m", "B", "y"};
        foreach (letters[i])
            send_cipher(letters[i]);
    endtask

    task automatic test_position_and_ignored();
        send_position(2'd0, 5'd31);
        send_position(2'd1, 5'd26);
        send_position(2'd2, 5'd0);
        send_position(2'd3, 5'd5);
        send_item(rsc_pkg::ACT_NONE, "K", 2'd1, 5'd3, 5'd3);
        send_item(rsc_pkg::ACT_NONE, 8'hFF, 2'd3, 5'd31, 5'd31);
        send_cipher("K");
        send_cipher("k");
    endtask

    task automatic test_odometer_carry();
        for (int r = 0; r < rsc_pkg::ROTORS; r++)
            send_position(2'(r), 5'd25);
        send_cipher("Q");
        send_cipher("q");
        send_position(2'd0, 5'd25);
        send_position(2'd1, 5'd3);
        send_cipher("N");
        send_cipher("?");
        send_cipher("w");
    endtask

    task automatic test_drain_pause();
        receiver_stalls = 1'b1;
        repeat (10) send_cipher(8'($urandom_range(0, 255)));
        wait_for_results();
        send_item(rsc_pkg::ACT_LOAD, 8'h00, 2'd1, 5'($urandom_range(0, 25)),
                  5'($urandom_range(0, 31)));
        repeat (5) send_cipher("E");
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_cipher(($urandom_range(0, 1) ? rsc_pkg::LOWER_A : rsc_pkg::UPPER_A) +
                        8'($urandom_range(0, 25)));
        else if (pick < 80)
            send_cipher(8'($urandom_range(0, 255)));
        else if (pick < 88)
            send_item(rsc_pkg::ACT_LOAD, 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)),
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        else if (pick < 95)
            send_position(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
        else
            send_item(rsc_pkg::ACT_NONE, 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)),
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    endtask

    task automatic test_random_mix();
        for (int chunk = 0; chunk < 8; chunk++) begin
            sender_idles    = 1'($urandom_range(0, 1));
            receiver_stalls = 1'($urandom_range(0, 1));
            repeat (25) random_item();
        end
    endtask

    task automatic test_back_to_back();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        repeat (60) random_item();
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_passthrough();
        test_wiring_load();
        test_letter_extremes();
        test_position_and_ignored();
        test_odometer_carry();
        test_drain_pause();
        test_random_mix();
        test_back_to_back();

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("rotor_substitution_cipher verification clean");
        else
            $display("rotor_substitution_cipher verification failed");
        $finish;
    end

endmodule
